/* rtl/core/mi_pkg.sv */
// ----------------------------------------------------------------------------
// mi_pkg
// Shared types, widths and cofactor tables of the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mi_pkg;

	localparam int ELEM_W = 32;
	// magnitude of a 3x3 minor (six triple products of 32-bit values)
	localparam int MAG_W  = 96;
	localparam int ADJ_W  = MAG_W + 1;
	// one determinant term: adjugate entry times a row 0 element
	localparam int DP_W   = 128;
	localparam int DET_W  = DP_W + 2;
	localparam int DEN_W  = DET_W - 1;
	// quotient bits resolved by the divider before saturation
	localparam int QB     = 33;
	localparam logic [2:0] LAST_TERM = 3'd5;

	typedef logic [15:0][ELEM_W-1:0] mat_t;
	typedef logic [3:0][ELEM_W-1:0]  row_t;

	typedef struct packed {
		logic det_rdy;
		logic done;
	} lane_stat_t;

	// index of the a-th kept row or column when index skip is struck out
	function automatic logic [1:0] minor_idx(input logic [1:0] skip, input logic [1:0] a);
		return (a < skip) ? a : a + 2'd1;
	endfunction

	// column chosen for factor a of term t of a 3x3 determinant
	function automatic logic [1:0] perm(input logic [2:0] t, input logic [1:0] a);
		logic [5:0] p;
		case (t)
			3'd0:    p = {2'd2, 2'd1, 2'd0};
			3'd1:    p = {2'd1, 2'd2, 2'd0};
			3'd2:    p = {2'd2, 2'd0, 2'd1};
			3'd3:    p = {2'd0, 2'd2, 2'd1};
			3'd4:    p = {2'd1, 2'd0, 2'd2};
			3'd5:    p = {2'd0, 2'd1, 2'd2};
			default: p = {2'd2, 2'd1, 2'd0};
		endcase
		return p[{a, 1'b0} +: 2];
	endfunction

	function automatic logic term_neg(input logic [2:0] t);
		return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
	endfunction

	function automatic logic [ELEM_W-1:0] abs32(input logic [ELEM_W-1:0] v);
		return v[ELEM_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

/* rtl/core/mat4_inverse.sv */
// ----------------------------------------------------------------------------
// mat4_inverse
// Inverse of a 4x4 signed fixed-point matrix by the adjugate method.
// ----------------------------------------------------------------------------
// Input channel: one transfer per matrix row (row_index, elem_0..elem_3).
// Rows 0..2 are stored and give no result; a row 3 transfer stores its row
// and starts the inverse. Stored rows persist, so a new matrix may reload
// only the rows that change.
// Output channel: four transfers, inverse rows 0..3 in order, last on row 3.
// singular marks a zero determinant (elements then zero); overflow marks a
// row where an element saturated.
// Four lanes, one per inverse row, each own a 32x32 multiplier and a
// restoring divider. After the row 3 transfer a start register launches
// the lanes; they form the cofactor products and their determinant term,
// the merge sums the determinant, each lane runs its four divisions and
// the output register takes the first inverse row.
// No new matrix is taken before the last result row of the previous one:
// in_ready stays low from the row 3 transfer until the last row transfers.
// A stalled receiver holds the current row; lanes keep their results.
// Reset clears control only; the matrix store is undefined until written.
// ----------------------------------------------------------------------------
module mat4_inverse #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  row_index,
	input  logic [31:0] elem_0,
	input  logic [31:0] elem_1,
	input  logic [31:0] elem_2,
	input  logic [31:0] elem_3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_row,
	output logic [31:0] inv_0,
	output logic [31:0] inv_1,
	output logic [31:0] inv_2,
	output logic [31:0] inv_3,
	output logic        singular,
	output logic        overflow,
	output logic        last
);
	mi_pkg::mat_t                             m_q;
	logic                                     busy_q;
	logic                                     start_q;
	logic                                     in_xfer;
	logic                                     finished;

	mi_pkg::lane_stat_t [3:0]                 stat;
	logic [3:0][mi_pkg::DP_W-1:0]             det_part;
	mi_pkg::row_t [3:0]                       res;
	logic [3:0]                               ovf;
	logic signed [mi_pkg::DET_W-1:0]          det;
	logic                                     det_zero;
	logic                                     det_go;

	assign in_ready = !busy_q;
	assign in_xfer  = in_valid & in_ready;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_q[{row_index, 2'd0}] <= elem_0;
			m_q[{row_index, 2'd1}] <= elem_1;
			m_q[{row_index, 2'd2}] <= elem_2;
			m_q[{row_index, 2'd3}] <= elem_3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= in_xfer && (row_index == 2'd3);
			if (in_xfer && (row_index == 2'd3)) busy_q <= 1'b1;
			else if (finished) busy_q <= 1'b0;
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		mi_lane #(
			.FRAC_BITS (FRAC_BITS),
			.LANE_ID   (l)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (start_q),
			.mat      (m_q),
			.det_go   (det_go),
			.det      (det),
			.det_zero (det_zero),
			.det_part (det_part[l]),
			.stat     (stat[l]),
			.res      (res[l]),
			.ovf      (ovf[l])
		);
	end

	mi_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.det_part  (det_part),
		.res       (res),
		.ovf       (ovf),
		.det       (det),
		.det_zero  (det_zero),
		.det_go    (det_go),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.inv_0     (inv_0),
		.inv_1     (inv_1),
		.inv_2     (inv_2),
		.inv_3     (inv_3),
		.singular  (singular),
		.overflow  (overflow),
		.last      (last),
		.finished  (finished)
	);

	// no new row is taken while results are pending
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while results pending");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && row_index == 2'd3) |=> !in_ready)
		else $error("block not busy after row 3 transfer");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (out_row == 2'd3)))
		else $error("last flag does not match row");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && singular) |-> (inv_0 == '0 && inv_1 == '0 && inv_2 == '0
			&& inv_3 == '0 && !overflow))
		else $error("singular row carries data");

endmodule

/* rtl/core/mi_div.sv */
// ----------------------------------------------------------------------------
// mi_div
// Restoring divider: rounded, saturated quotient num * 2^(2F) / den.
// ----------------------------------------------------------------------------
module mi_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mi_pkg::MAG_W-1:0]    num_mag,
	input  logic [mi_pkg::DEN_W-1:0]    den_mag,
	input  logic                        neg,
	output logic                        done,
	output logic [mi_pkg::ELEM_W-1:0]   quo,
	output logic                        sat
);
	localparam int NUM_W = mi_pkg::MAG_W + 2 * FRAC_BITS;
	localparam int DSH_W = mi_pkg::DEN_W + mi_pkg::QB;
	localparam int WW    = ((NUM_W > DSH_W) ? NUM_W : DSH_W) + 1;

	typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_RND} dstate_t;

	dstate_t                       state_q;
	logic [WW-1:0]                 r_q;
	logic [WW-1:0]                 ds_q;
	logic [mi_pkg::DEN_W-1:0]      d_q;
	logic [mi_pkg::QB-1:0]         q_q;
	logic [5:0]                    cnt_q;
	logic                          neg_q;
	logic                          done_q;
	logic [mi_pkg::ELEM_W-1:0]     quo_q;
	logic                          sat_q;

	logic                          ge;
	logic                          rnd_up;
	logic [mi_pkg::QB:0]           q1;
	logic [mi_pkg::QB:0]           limit;

	assign ge     = (r_q >= ds_q);
	assign rnd_up = ({r_q[mi_pkg::DEN_W-1:0], 1'b0} >= {1'b0, d_q});
	assign q1     = {1'b0, q_q} + {{mi_pkg::QB{1'b0}}, rnd_up};
	assign limit  = neg_q ? (mi_pkg::QB+1)'(34'h080000000) : (mi_pkg::QB+1)'(34'h07FFFFFFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						r_q     <= WW'(num_mag) << (2 * FRAC_BITS);
						ds_q    <= WW'(den_mag) << mi_pkg::QB;
						d_q     <= den_mag;
						neg_q   <= neg;
						state_q <= D_CHK;
					end
				end
				D_CHK: begin
					// quotient of 2^33 or more saturates whatever the rounding
					if (ge) begin
						quo_q   <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
						sat_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						ds_q    <= ds_q >> 1;
						cnt_q   <= 6'(mi_pkg::QB - 1);
						q_q     <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (ge) r_q <= r_q - ds_q;
					q_q  <= {q_q[mi_pkg::QB-2:0], ge};
					ds_q <= ds_q >> 1;
					if (cnt_q == 6'd0) state_q <= D_RND;
					else cnt_q <= cnt_q - 6'd1;
				end
				D_RND: begin
					if (q1 > limit) begin
						quo_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
						sat_q <= 1'b1;
					end else begin
						quo_q <= neg_q ? (~q1[mi_pkg::ELEM_W-1:0] + 1'b1) : q1[mi_pkg::ELEM_W-1:0];
						sat_q <= 1'b0;
					end
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign sat  = sat_q;

endmodule

/* rtl/core/mi_lane.sv */
// ----------------------------------------------------------------------------
// mi_lane
// One lane per inverse row: four adjugate entries, a determinant term and
// the four scaled divisions of that row.
// ----------------------------------------------------------------------------
module mi_lane #(
	parameter int FRAC_BITS = 16,
	parameter int LANE_ID   = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  mi_pkg::mat_t                      mat,
	input  logic                              det_go,
	input  logic signed [mi_pkg::DET_W-1:0]   det,
	input  logic                              det_zero,
	output logic signed [mi_pkg::DP_W-1:0]    det_part,
	output mi_pkg::lane_stat_t                stat,
	output mi_pkg::row_t                      res,
	output logic                              ovf
);
	localparam logic [1:0] LID = 2'(LANE_ID);

	typedef enum logic [3:0] {
		L_IDLE, L_M1, L_M2, L_M3, L_ACC, L_ADJ, L_DM, L_DA, L_DWAIT, L_DIVS, L_DIVW, L_DONE
	} lstate_t;

	lstate_t                               state_q;
	logic [1:0]                            e_q;
	logic [2:0]                            t_q;
	logic [1:0]                            k_q;
	logic                                  sgn_q;
	logic                                  dsgn_q;
	logic [63:0]                           p_q;
	logic [31:0]                           hi_q;
	logic [63:0]                           lo_q;
	logic signed [mi_pkg::ADJ_W-1:0]       acc_q;
	logic signed [mi_pkg::ADJ_W-1:0]       adj_q [4];
	logic [mi_pkg::DP_W-1:0]               dres_q;
	mi_pkg::row_t                          res_q;
	logic                                  ovf_q;

	logic [1:0]                            r0, r1, r2;
	logic [31:0]                           x, y, z, m0;
	logic [31:0]                           mul_a, mul_b;
	logic [63:0]                           mul_p;
	logic [mi_pkg::MAG_W-1:0]              mag;
	logic signed [mi_pkg::ADJ_W-1:0]       adj_cur;
	logic [mi_pkg::ADJ_W-1:0]              adj0_abs;
	logic [mi_pkg::ADJ_W-1:0]              adje_abs;
	logic [mi_pkg::DET_W-1:0]              det_abs;
	logic                                  div_done;
	logic [31:0]                           div_quo;
	logic                                  div_sat;

	always_comb begin
		r0 = mi_pkg::minor_idx(e_q, 2'd0);
		r1 = mi_pkg::minor_idx(e_q, 2'd1);
		r2 = mi_pkg::minor_idx(e_q, 2'd2);
		x  = mat[{r0, mi_pkg::minor_idx(LID, mi_pkg::perm(t_q, 2'd0))}];
		y  = mat[{r1, mi_pkg::minor_idx(LID, mi_pkg::perm(t_q, 2'd1))}];
		z  = mat[{r2, mi_pkg::minor_idx(LID, mi_pkg::perm(t_q, 2'd2))}];
		m0 = mat[{2'd0, LID}];
		adj0_abs = adj_q[0][mi_pkg::ADJ_W-1] ? -adj_q[0] : adj_q[0];
		adj_cur  = adj_q[e_q];
		adje_abs = adj_cur[mi_pkg::ADJ_W-1] ? -adj_cur : adj_cur;
		det_abs  = det[mi_pkg::DET_W-1] ? -det : det;
		mag = {p_q, 32'b0} + {32'b0, lo_q};
		case (state_q)
			L_M1: begin
				mul_a = mi_pkg::abs32(x);
				mul_b = mi_pkg::abs32(y);
			end
			L_M2: begin
				mul_a = p_q[31:0];
				mul_b = mi_pkg::abs32(z);
			end
			L_M3: begin
				mul_a = hi_q;
				mul_b = mi_pkg::abs32(z);
			end
			L_DM: begin
				mul_a = adj0_abs[32*k_q +: 32];
				mul_b = mi_pkg::abs32(m0);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			unique case (state_q)
				L_IDLE, L_DONE: begin
					if (start) begin
						e_q     <= '0;
						t_q     <= '0;
						acc_q   <= '0;
						state_q <= L_M1;
					end
				end
				L_M1: begin
					p_q     <= mul_p;
					sgn_q   <= x[31] ^ y[31] ^ mi_pkg::term_neg(t_q);
					state_q <= L_M2;
				end
				L_M2: begin
					hi_q    <= p_q[63:32];
					p_q     <= mul_p;
					sgn_q   <= sgn_q ^ z[31];
					state_q <= L_M3;
				end
				L_M3: begin
					lo_q    <= p_q;
					p_q     <= mul_p;
					state_q <= L_ACC;
				end
				L_ACC: begin
					acc_q <= sgn_q ? acc_q - $signed({1'b0, mag}) : acc_q + $signed({1'b0, mag});
					if (t_q == mi_pkg::LAST_TERM) begin
						state_q <= L_ADJ;
					end else begin
						t_q     <= t_q + 3'd1;
						state_q <= L_M1;
					end
				end
				L_ADJ: begin
					// checkerboard sign of the cofactor
					adj_q[e_q] <= (LID[0] ^ e_q[0]) ? -acc_q : acc_q;
					acc_q <= '0;
					t_q   <= '0;
					if (e_q == 2'd3) begin
						k_q     <= '0;
						dres_q  <= '0;
						state_q <= L_DM;
					end else begin
						e_q     <= e_q + 2'd1;
						state_q <= L_M1;
					end
				end
				L_DM: begin
					p_q     <= mul_p;
					dsgn_q  <= adj_q[0][mi_pkg::ADJ_W-1] ^ m0[31];
					state_q <= L_DA;
				end
				L_DA: begin
					dres_q[32*k_q +: 64] <= dres_q[32*k_q +: 64] + p_q;
					if (k_q == 2'd2) begin
						state_q <= L_DWAIT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= L_DM;
					end
				end
				L_DWAIT: begin
					if (det_go) begin
						ovf_q <= 1'b0;
						e_q   <= '0;
						if (det_zero) begin
							res_q   <= '0;
							state_q <= L_DONE;
						end else begin
							state_q <= L_DIVS;
						end
					end
				end
				L_DIVS: state_q <= L_DIVW;
				L_DIVW: begin
					if (div_done) begin
						res_q[e_q] <= div_quo;
						ovf_q      <= ovf_q | div_sat;
						if (e_q == 2'd3) begin
							state_q <= L_DONE;
						end else begin
							e_q     <= e_q + 2'd1;
							state_q <= L_DIVS;
						end
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	mi_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == L_DIVS),
		.num_mag (adje_abs[mi_pkg::MAG_W-1:0]),
		.den_mag (det_abs[mi_pkg::DEN_W-1:0]),
		.neg     (adj_cur[mi_pkg::ADJ_W-1] ^ det[mi_pkg::DET_W-1]),
		.done    (div_done),
		.quo     (div_quo),
		.sat     (div_sat)
	);

	assign det_part     = dsgn_q ? -$signed(dres_q) : $signed(dres_q);
	assign stat.det_rdy = (state_q == L_DWAIT);
	assign stat.done    = (state_q == L_DONE);
	assign res          = res_q;
	assign ovf          = ovf_q;

endmodule

/* rtl/core/mi_merge.sv */
// ----------------------------------------------------------------------------
// mi_merge
// Sums the lane determinant terms, hands the determinant back to the lanes
// and sends the four inverse rows out through the output register.
// ----------------------------------------------------------------------------
module mi_merge (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mi_pkg::lane_stat_t [3:0]               stat,
	input  logic [3:0][mi_pkg::DP_W-1:0]           det_part,
	input  mi_pkg::row_t [3:0]                     res,
	input  logic [3:0]                             ovf,
	output logic signed [mi_pkg::DET_W-1:0]        det,
	output logic                                   det_zero,
	output logic                                   det_go,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             out_row,
	output logic [mi_pkg::ELEM_W-1:0]              inv_0,
	output logic [mi_pkg::ELEM_W-1:0]              inv_1,
	output logic [mi_pkg::ELEM_W-1:0]              inv_2,
	output logic [mi_pkg::ELEM_W-1:0]              inv_3,
	output logic                                   singular,
	output logic                                   overflow,
	output logic                                   last,
	output logic                                   finished
);
	typedef enum logic [2:0] {M_IDLE, M_S1, M_S2, M_GO, M_WAIT, M_OUT} mstate_t;

	mstate_t                            state_q;
	logic signed [mi_pkg::DP_W:0]       pair_q [2];
	logic signed [mi_pkg::DET_W-1:0]    det_q;
	logic                               valid_q;
	logic [1:0]                         row_q;
	mi_pkg::row_t                       inv_q;
	logic                               sing_q;
	logic                               ovf_q;
	logic                               last_q;
	logic                               all_rdy;
	logic                               all_done;
	logic                               xfer;

	assign all_rdy  = stat[0].det_rdy & stat[1].det_rdy & stat[2].det_rdy & stat[3].det_rdy;
	assign all_done = stat[0].done & stat[1].done & stat[2].done & stat[3].done;
	assign xfer     = valid_q & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				M_IDLE: if (all_rdy) state_q <= M_S1;
				M_S1: begin
					pair_q[0] <= $signed({det_part[0][mi_pkg::DP_W-1], det_part[0]})
						+ $signed({det_part[1][mi_pkg::DP_W-1], det_part[1]});
					pair_q[1] <= $signed({det_part[2][mi_pkg::DP_W-1], det_part[2]})
						+ $signed({det_part[3][mi_pkg::DP_W-1], det_part[3]});
					state_q <= M_S2;
				end
				M_S2: begin
					det_q   <= $signed({pair_q[0][mi_pkg::DP_W], pair_q[0]})
						+ $signed({pair_q[1][mi_pkg::DP_W], pair_q[1]});
					state_q <= M_GO;
				end
				M_GO: state_q <= M_WAIT;
				M_WAIT: begin
					if (all_done) begin
						valid_q <= 1'b1;
						row_q   <= 2'd0;
						inv_q   <= res[0];
						ovf_q   <= ovf[0];
						sing_q  <= det_zero;
						last_q  <= 1'b0;
						state_q <= M_OUT;
					end
				end
				M_OUT: begin
					if (xfer) begin
						if (last_q) begin
							valid_q <= 1'b0;
							state_q <= M_IDLE;
						end else begin
							row_q  <= row_q + 2'd1;
							inv_q  <= res[row_q + 2'd1];
							ovf_q  <= ovf[row_q + 2'd1];
							last_q <= (row_q == 2'd2);
						end
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign det       = det_q;
	assign det_zero  = (det_q == '0);
	assign det_go    = (state_q == M_GO);
	assign out_valid = valid_q;
	assign out_row   = row_q;
	assign inv_0     = inv_q[0];
	assign inv_1     = inv_q[1];
	assign inv_2     = inv_q[2];
	assign inv_3     = inv_q[3];
	assign singular  = sing_q;
	assign overflow  = ovf_q;
	assign last      = last_q;
	assign finished  = xfer & last_q;

endmodule

/* tb/mat4_inverse_checker.sv */
// ----------------------------------------------------------------------------
// mat4_inverse_checker
// Watches both channels of the matrix inverse, keeps its own copy of the
// stored rows, predicts the four inverse rows on every row 3 transfer with
// exact wide arithmetic and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module mat4_inverse_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  row_index,
	input  logic [31:0] elem_0,
	input  logic [31:0] elem_1,
	input  logic [31:0] elem_2,
	input  logic [31:0] elem_3,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  out_row,
	input  logic [31:0] inv_0,
	input  logic [31:0] inv_1,
	input  logic [31:0] inv_2,
	input  logic [31:0] inv_3,
	input  logic        singular,
	input  logic        overflow,
	input  logic        last,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [191:0] wide_t;
	typedef logic [191:0] mag_t;

	typedef struct {
		logic [1:0]  row;
		logic [31:0] v [4];
		logic        sing;
		logic        ovf;
		logic        lst;
	} inv_row_t;

	logic [31:0] store [16];
	inv_row_t inv_rows_q [$];

	function automatic wide_t sx(input logic [31:0] v);
		return wide_t'($signed(v));
	endfunction

	// signed cofactor for inverse row i, column j: minor without row j, column i
	function automatic wide_t cofactor(input int i, input int j);
		int rr [3];
		int cc [3];
		int nr;
		int nc;
		wide_t a [3][3];
		wide_t s;
		nr = 0;
		nc = 0;
		for (int k = 0; k < 4; k++) begin
			if (k != j) begin
				rr[nr] = k;
				nr++;
			end
			if (k != i) begin
				cc[nc] = k;
				nc++;
			end
		end
		for (int p = 0; p < 3; p++)
			for (int q = 0; q < 3; q++)
				a[p][q] = sx(store[rr[p]*4 + cc[q]]);
		s = a[0][0]*a[1][1]*a[2][2] - a[0][0]*a[1][2]*a[2][1]
		  - a[0][1]*a[1][0]*a[2][2] + a[0][1]*a[1][2]*a[2][0]
		  + a[0][2]*a[1][0]*a[2][1] - a[0][2]*a[1][1]*a[2][0];
		return ((i + j) % 2) ? -s : s;
	endfunction

	// rounded (ties away from zero) and saturated adj * 2^(2F) / det
	function automatic logic [31:0] scaled_div(input wide_t adj, input wide_t det,
			inout logic sat);
		logic neg;
		mag_t n;
		mag_t d;
		mag_t q;
		mag_t r;
		mag_t lim;
		neg = adj[191] ^ det[191];
		n = adj[191] ? mag_t'(-adj) : mag_t'(adj);
		d = det[191] ? mag_t'(-det) : mag_t'(det);
		n = n << (2*FRAC_BITS);
		q = n / d;
		r = n % d;
		if ((r << 1) >= d)
			q = q + 1;
		lim = neg ? mag_t'(64'h8000_0000) : mag_t'(64'h7FFF_FFFF);
		if (q > lim) begin
			sat = 1'b1;
			return lim[31:0];
		end
		return neg ? (32'd0 - q[31:0]) : q[31:0];
	endfunction

	function automatic void predict_inverse();
		wide_t adj [16];
		wide_t det;
		inv_row_t e;
		for (int k = 0; k < 16; k++)
			adj[k] = cofactor(k / 4, k % 4);
		det = '0;
		for (int j = 0; j < 4; j++)
			det = det + adj[j*4] * sx(store[j]);
		for (int i = 0; i < 4; i++) begin
			e.row = i[1:0];
			e.sing = (det == 0);
			e.ovf = 1'b0;
			e.lst = (i == 3);
			for (int j = 0; j < 4; j++)
				e.v[j] = e.sing ? 32'd0 : scaled_div(adj[i*4 + j], det, e.ovf);
			inv_rows_q.push_back(e);
		end
	endfunction

	assign pending = inv_rows_q.size();

	always @(posedge clk) begin
		inv_row_t e;
		logic [31:0] got [4];
		if (arst_n && in_valid && in_ready) begin
			store[row_index*4 + 0] = elem_0;
			store[row_index*4 + 1] = elem_1;
			store[row_index*4 + 2] = elem_2;
			store[row_index*4 + 3] = elem_3;
			if (row_index == 2'd3)
				predict_inverse();
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{inv_0, inv_1, inv_2, inv_3};
			if (inv_rows_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transfer: row %0d", out_row);
			end else begin
				e = inv_rows_q.pop_front();
				if (out_row !== e.row || got[0] !== e.v[0] || got[1] !== e.v[1]
						|| got[2] !== e.v[2] || got[3] !== e.v[3] || singular !== e.sing
						|| overflow !== e.ovf || last !== e.lst) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch expected row %0d %h %h %h %h sing %b ovf %b last %b",
							e.row, e.v[0], e.v[1], e.v[2], e.v[3], e.sing, e.ovf, e.lst);
						$display("         actual   row %0d %h %h %h %h sing %b ovf %b last %b",
							out_row, got[0], got[1], got[2], got[3], singular, overflow, last);
					end
				end
			end
		end
	end

	initial errors = 0;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the 4x4 matrix inverse: directed matrices (identity, tiny and
// extreme elements, singular, row reuse) then random well-formed matrices
// with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  row_index;
	logic [31:0] elem_0, elem_1, elem_2, elem_3;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  out_row;
	logic [31:0] inv_0, inv_1, inv_2, inv_3;
	logic        singular, overflow, last;
	int          errors;
	int          pending;

	logic        calm;
	int          stall_left;
	int          idle_cycles;
	int          rows_sent;
	logic [31:0] sent [4][4];

	mat4_inverse DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .row_index(row_index),
		.elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
		.out_valid(out_valid), .out_ready(out_ready), .out_row(out_row),
		.inv_0(inv_0), .inv_1(inv_1), .inv_2(inv_2), .inv_3(inv_3),
		.singular(singular), .overflow(overflow), .last(last)
	);

	mat4_inverse_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .row_index(row_index),
		.elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
		.out_valid(out_valid), .out_ready(out_ready), .out_row(out_row),
		.inv_0(inv_0), .inv_1(inv_1), .inv_2(inv_2), .inv_3(inv_3),
		.singular(singular), .overflow(overflow), .last(last),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stall before each result, none while calm
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && out_ready) begin
			if (!calm && $urandom_range(0, 14) > 0) begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(0, 13);
			end
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_row(input logic [1:0] r, input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		row_index <= r;
		elem_0 <= a;
		elem_1 <= b;
		elem_2 <= c;
		elem_3 <= d;
		sent[r] = '{a, b, c, d};
		rows_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [31:0] rand_elem(input int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			default: return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
		endcase
	endfunction

	task automatic send_rand_row(input logic [1:0] r, input int mode);
		logic [31:0] e [4];
		for (int c = 0; c < 4; c++) begin
			e[c] = rand_elem(mode);
			// near identity keeps most matrices well conditioned
			if (mode == 2 && c == r)
				e[c] = e[c] + ($urandom_range(0, 1) ? 32'h0001_0000 : -32'h0001_0000);
		end
		send_row(r, e[0], e[1], e[2], e[3]);
	endtask

	initial begin
		int mode;
		int order [3];
		int tmp;
		int k;
		logic [31:0] one;
		one = 32'h0001_0000;
		arst_n = 1'b0;
		in_valid = 1'b0;
		row_index = '0;
		{elem_0, elem_1, elem_2, elem_3} = '0;
		calm = 1'b0;
		idle_cycles = 0;
		rows_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity
		for (int r = 0; r < 4; r++)
			send_row(2'(r), r == 0 ? one : 0, r == 1 ? one : 0, r == 2 ? one : 0,
				r == 3 ? one : 0);
		// tiny diagonal saturates every diagonal inverse element
		for (int r = 0; r < 4; r++)
			send_row(2'(r), r == 0 ? 1 : 0, r == 1 ? 1 : 0, r == 2 ? 1 : 0, r == 3 ? 1 : 0);
		// zero last row reuses stored rows: singular
		send_row(3, 0, 0, 0, 0);
		// negative diagonal
		for (int r = 0; r < 4; r++)
			send_row(2'(r), r == 0 ? -2*one : 0, r == 1 ? -2*one : 0, r == 2 ? -2*one : 0,
				r == 3 ? -2*one : 0);
		// sender holds off until every result has come
		wait (pending == 0);
		// extreme elements
		send_row(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		send_row(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_row(2, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
		send_row(3, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		// only row 3 reloaded
		send_row(3, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

		while (rows_sent < 120) begin
			calm = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 5);
			mode = (mode == 0) ? 0 : (mode == 1) ? 1 : 2;
			order = '{0, 1, 2};
			for (int i = 2; i > 0; i--) begin
				k = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[k];
				order[k] = tmp;
			end
			for (int i = 0; i < 3; i++)
				if ($urandom_range(0, 4) > 0)
					send_rand_row(2'(order[i]), mode);
			if ($urandom_range(0, 9) == 0) begin
				// loads without a row 3
				send_rand_row(2'($urandom_range(0, 2)), mode);
			end else if ($urandom_range(0, 9) == 0) begin
				// copy of a stored row: singular
				k = $urandom_range(0, 2);
				send_row(3, sent[k][0], sent[k][1], sent[k][2], sent[k][3]);
			end else begin
				send_rand_row(3, mode);
			end
		end
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
